[src/bracket_scan_tape_machine_defines.svh]
// Assertion macros used by the tape machine top level.
`ifndef BRACKET_SCAN_TAPE_MACHINE_DEFINES_SVH
`define BRACKET_SCAN_TAPE_MACHINE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define BSTM_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BSTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bstm_pkg.sv]
// Package: command codes, tape command and result word types for the tape machine.
`default_nettype none

package bstm_pkg;

    // Instruction bytes
    localparam logic [7:0] CH_LEFT  = 8'h3C; // '<'
    localparam logic [7:0] CH_RIGHT = 8'h3E; // '>'
    localparam logic [7:0] CH_INC   = 8'h2B; // '+'
    localparam logic [7:0] CH_DEC   = 8'h2D; // '-'
    localparam logic [7:0] CH_IN    = 8'h2C; // ','
    localparam logic [7:0] CH_OUT   = 8'h2E; // '.'
    localparam logic [7:0] CH_OPEN  = 8'h5B; // '['
    localparam logic [7:0] CH_CLOSE = 8'h5D; // ']'
    localparam logic [7:0] CH_HALT  = 8'h21; // '!'

    // Request from the execute logic to the tape store
    typedef struct packed {
        logic       wr;      // write wr_data to the current cell
        logic [7:0] wr_data;
        logic       move;    // pointer moves, fetch the new cell
    } t_tape_cmd;

    // One result word
    typedef struct packed {
        logic [6:0] next_pc;
        logic       in_taken;
        logic       out_valid;
        logic [7:0] out_byte;
        logic       halted;
    } t_result;

endpackage

`default_nettype wire

[src/bstm_tape.sv]
// Tape store: cell memory, clearing sweep after reset and current-cell cache.
`default_nettype none

module bstm_tape #(
    parameter int TAPE_SIZE = 8192
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bstm_pkg::t_tape_cmd           i_cmd,
    input  wire logic [$clog2(TAPE_SIZE)-1:0]  i_ptr,
    input  wire logic [$clog2(TAPE_SIZE)-1:0]  i_new_ptr,
    output logic      [7:0]                    o_cell,
    output logic                               o_clearing
);
    import bstm_pkg::*;

    localparam int TP_W = $clog2(TAPE_SIZE);
    localparam logic [TP_W-1:0] TP_LAST = TP_W'(TAPE_SIZE - 1);

    logic [7:0]      r_mem [TAPE_SIZE];
    logic [7:0]      r_rd_data;
    logic [7:0]      r_cell;
    logic            r_use_rd;
    logic            r_clr;
    logic [TP_W-1:0] r_clr_addr;

    logic            w_we;
    logic [TP_W-1:0] w_waddr;
    logic [7:0]      w_wdata;

    // Single write port shared by the clearing sweep and the execute logic
    assign w_we    = r_clr | i_cmd.wr;
    assign w_waddr = r_clr ? r_clr_addr : i_ptr;
    assign w_wdata = r_clr ? 8'h00 : i_cmd.wr_data;

    // Memory: write port and registered read of the cell under the new pointer
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.move) begin
            r_rd_data <= r_mem[i_new_ptr];
        end
    end

    // Clearing sweep and cache of the current cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_cell     <= 8'h00;
            r_use_rd   <= 1'b0;
        end else begin
            if (r_clr) begin
                if (r_clr_addr == TP_LAST) begin
                    r_clr <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + TP_W'(1);
            end
            if (i_cmd.wr) begin
                r_cell   <= i_cmd.wr_data;
                r_use_rd <= 1'b0;
            end else if (i_cmd.move) begin
                r_use_rd <= 1'b1;
            end
        end
    end

    // After a move the fresh read data is the cell, otherwise the cached value
    assign o_cell     = r_use_rd ? r_rd_data : r_cell;
    assign o_clearing = r_clr;

endmodule

`default_nettype wire

[src/bracket_scan_tape_machine.sv]
// Top level: tape machine core with execute logic, pointer state and output skid.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------------
//  in      | input     | i_valid / o_stall  | i_instr_byte, i_in_byte
//  out     | output    | o_valid / i_stall  | o_next_pc, o_in_taken, o_out_valid,
//          |           |                    | o_out_byte, o_halted
//
// One word is accepted per cycle while o_stall is low; its result word is registered.
// The execute step is one pass from the state registers and the cached tape cell
// to the result register; a pointer move refetches the cell in the same edge.
// After reset the tape is cleared one cell per cycle, with o_stall high until the sweep ends.
// A two-entry output (register plus skid) lets a word in while a result waits;
// o_stall rises when both entries are full and while the tape is being cleared.
`default_nettype none

module bracket_scan_tape_machine #(
    parameter int PROGRAM_SIZE = 128,
    parameter int TAPE_SIZE    = 8192
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_instr_byte,
    input  wire logic [7:0] i_in_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic      [6:0] o_next_pc,
    output logic            o_in_taken,
    output logic            o_out_valid,
    output logic      [7:0] o_out_byte,
    output logic            o_halted
);
    import bstm_pkg::*;

`include "bracket_scan_tape_machine_defines.svh"

    localparam int PC_W = $clog2(PROGRAM_SIZE);
    localparam int TP_W = $clog2(TAPE_SIZE);
    localparam logic [PC_W-1:0] PC_LAST = PC_W'(PROGRAM_SIZE - 1);
    localparam logic [TP_W-1:0] TP_LAST = TP_W'(TAPE_SIZE - 1);

    // Machine state
    logic [PC_W-1:0]    r_pc,        n_pc;
    logic [TP_W-1:0]    r_tp,        n_tp;
    logic               r_scanning,  n_scanning;
    logic               r_scan_back, n_scan_back;
    logic signed [8:0]  r_depth,     n_depth;
    logic               r_stopped,   n_stopped;

    // Output register and skid
    t_result            r_out;
    logic               r_ovld;
    t_result            r_skid;
    logic               r_skid_vld;

    t_result            w_res;
    t_tape_cmd          w_cmd;
    logic [7:0]         w_cell;
    logic               w_clearing;
    logic               w_acc;
    logic               w_take;
    logic [PC_W-1:0]    w_pc_inc;
    logic [PC_W-1:0]    w_pc_dec;
    logic signed [9:0]  w_depth_sum;

    assign o_stall = w_clearing | r_skid_vld;
    assign w_acc   = i_valid & ~o_stall;
    assign w_take  = r_ovld & ~i_stall;

    assign w_pc_inc = (r_pc == PC_LAST) ? '0 : r_pc + PC_W'(1);
    assign w_pc_dec = (r_pc == '0) ? PC_LAST : r_pc - PC_W'(1);

    // Execute one instruction word
    always_comb begin
        n_pc        = r_pc;
        n_tp        = r_tp;
        n_scanning  = r_scanning;
        n_scan_back = r_scan_back;
        n_depth     = r_depth;
        n_stopped   = r_stopped;
        w_depth_sum = {r_depth[8], r_depth};
        w_cmd       = '0;
        w_res       = '0;

        if (!r_stopped) begin
            n_pc = r_scan_back ? w_pc_dec : w_pc_inc;
            if (i_instr_byte == CH_HALT) begin
                n_stopped = 1'b1;
            end else if (r_scanning) begin
                // count brackets; depth folds to zero at +-256
                if (i_instr_byte == CH_OPEN) begin
                    w_depth_sum = w_depth_sum + 10'sd1;
                end else if (i_instr_byte == CH_CLOSE) begin
                    w_depth_sum = w_depth_sum - 10'sd1;
                end
                if (w_depth_sum == 10'sd256 || w_depth_sum == -10'sd256) begin
                    n_depth = '0;
                end else begin
                    n_depth = 9'(w_depth_sum);
                end
                if (n_depth == '0) begin
                    n_scanning  = 1'b0;
                    n_scan_back = 1'b0;
                    n_pc        = w_pc_inc;
                end
            end else begin
                unique case (i_instr_byte)
                    CH_LEFT: begin
                        n_tp       = (r_tp == '0) ? TP_LAST : r_tp - TP_W'(1);
                        w_cmd.move = 1'b1;
                    end
                    CH_RIGHT: begin
                        n_tp       = (r_tp == TP_LAST) ? '0 : r_tp + TP_W'(1);
                        w_cmd.move = 1'b1;
                    end
                    CH_IN: begin
                        w_cmd.wr       = 1'b1;
                        w_cmd.wr_data  = i_in_byte;
                        w_res.in_taken = 1'b1;
                    end
                    CH_OUT: begin
                        w_res.out_valid = 1'b1;
                        w_res.out_byte  = w_cell;
                    end
                    CH_INC: begin
                        w_cmd.wr      = 1'b1;
                        w_cmd.wr_data = w_cell + 8'd1;
                    end
                    CH_DEC: begin
                        w_cmd.wr      = 1'b1;
                        w_cmd.wr_data = w_cell - 8'd1;
                    end
                    CH_OPEN: begin
                        if (w_cell == 8'h00) begin
                            n_depth     = 9'sd1;
                            n_scan_back = 1'b0;
                            n_scanning  = 1'b1;
                        end
                    end
                    CH_CLOSE: begin
                        if (w_cell != 8'h00) begin
                            n_pc        = w_pc_dec;
                            n_depth     = -9'sd1;
                            n_scan_back = 1'b1;
                            n_scanning  = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        w_res.next_pc = 7'(n_pc);
        w_res.halted  = n_stopped;

        // tape requests only for accepted words
        w_cmd.wr   = w_cmd.wr & w_acc;
        w_cmd.move = w_cmd.move & w_acc;
    end

    bstm_tape #(
        .TAPE_SIZE (TAPE_SIZE)
    ) u_tape (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_ptr      (r_tp),
        .i_new_ptr  (n_tp),
        .o_cell     (w_cell),
        .o_clearing (w_clearing)
    );

    // State update on accepted words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_tp        <= '0;
            r_scanning  <= 1'b0;
            r_scan_back <= 1'b0;
            r_depth     <= '0;
            r_stopped   <= 1'b0;
        end else if (w_acc) begin
            r_pc        <= n_pc;
            r_tp        <= n_tp;
            r_scanning  <= n_scanning;
            r_scan_back <= n_scan_back;
            r_depth     <= n_depth;
            r_stopped   <= n_stopped;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld     <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (w_acc) begin
            if (!r_ovld || w_take) begin
                r_out  <= w_res;
                r_ovld <= 1'b1;
            end else begin
                r_skid     <= w_res;
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_ovld <= 1'b0;
        end
    end

    assign o_valid     = r_ovld;
    assign o_next_pc   = r_out.next_pc;
    assign o_in_taken  = r_out.in_taken;
    assign o_out_valid = r_out.out_valid;
    assign o_out_byte  = r_out.out_byte;
    assign o_halted    = r_out.halted;

    // Checks
    `BSTM_ASSERT_ALWAYS(a_skid_behind_out, i_clk, i_rst_n, !r_skid_vld || r_ovld,
        "skid entry holds a word while the output register is empty")
    `BSTM_ASSERT_ALWAYS(a_idle_depth, i_clk, i_rst_n,
        r_scanning || (r_depth == '0 && !r_scan_back),
        "bracket depth or scan direction left set outside scan mode")
    `BSTM_ASSERT_ALWAYS(a_no_accept_clear, i_clk, i_rst_n, !(w_clearing && w_acc),
        "word accepted during the tape clearing sweep")
    `BSTM_ASSERT_NEXT(a_halt_holds, i_clk, i_rst_n, r_stopped,
        r_stopped && $stable(r_pc) && $stable(r_tp),
        "halted machine changed its pointers")

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the bracket-scan tape machine: scoreboard class, drivers, checks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bstm_pkg::*;

    localparam int CODE_LEN    = 128;
    localparam int TAPE_CELLS  = 8192;
    localparam int QUIET_LIMIT = 40000; // covers the tape clear after reset and the long hold
    localparam int SEND_IDLE [4] = '{0, 55, 0, 14};
    localparam int RECV_STALL[4] = '{0, 0, 55, 14};

    // Scoreboard: tracks machine state, predicts one result word per input word
    class tape_scoreboard;
        logic [6:0]  m_pc;
        logic [12:0] m_ptr;
        logic [7:0]  m_cells [TAPE_CELLS];
        bit          m_seeking;
        bit          m_seek_back;
        int          m_nest;
        bit          m_halted;
        t_result     pending_results [$];
        int          n_words, n_checked, n_errors, n_out, n_reads, n_scans;

        function new();
            foreach (m_cells[i]) m_cells[i] = 8'h00;
            m_pc        = '0;
            m_ptr       = '0;
            m_seeking   = 1'b0;
            m_seek_back = 1'b0;
            m_nest      = 0;
            m_halted    = 1'b0;
        endfunction

        // One instruction step; pointer widths match the sizes, so wrap is free
        function t_result execute(logic [7:0] instr, logic [7:0] in_b);
            t_result    r;
            logic [6:0] here;
            r    = '0;
            here = m_pc;
            if (!m_halted) begin
                m_pc = m_seek_back ? here - 7'd1 : here + 7'd1;
                if (instr == CH_HALT) begin
                    m_halted = 1'b1;
                end else if (m_seeking) begin
                    // bracket counting, truncating wrap of the depth
                    if (instr == CH_OPEN)  m_nest++;
                    if (instr == CH_CLOSE) m_nest--;
                    m_nest = m_nest % 256;
                    if (m_nest == 0) begin
                        m_seeking   = 1'b0;
                        m_seek_back = 1'b0;
                        m_pc        = here + 7'd1;
                    end
                end else begin
                    case (instr)
                        CH_LEFT:  m_ptr = m_ptr - 13'd1;
                        CH_RIGHT: m_ptr = m_ptr + 13'd1;
                        CH_IN: begin
                            m_cells[m_ptr] = in_b;
                            r.in_taken     = 1'b1;
                            n_reads++;
                        end
                        CH_OUT: begin
                            r.out_valid = 1'b1;
                            r.out_byte  = m_cells[m_ptr];
                            n_out++;
                        end
                        CH_INC: m_cells[m_ptr] = m_cells[m_ptr] + 8'd1;
                        CH_DEC: m_cells[m_ptr] = m_cells[m_ptr] - 8'd1;
                        CH_OPEN: begin
                            if (m_cells[m_ptr] == 8'h00) begin
                                m_nest      = 1;
                                m_seek_back = 1'b0;
                                m_seeking   = 1'b1;
                                n_scans++;
                            end
                        end
                        CH_CLOSE: begin
                            if (m_cells[m_ptr] != 8'h00) begin
                                m_pc        = here - 7'd1;
                                m_nest      = -1;
                                m_seek_back = 1'b1;
                                m_seeking   = 1'b1;
                                n_scans++;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            r.next_pc = m_pc;
            r.halted  = m_halted;
            return r;
        endfunction

        function void note_word(logic [7:0] instr, logic [7:0] in_b);
            n_words++;
            pending_results.push_back(execute(instr, in_b));
        endfunction

        function void check_word(t_result got);
            t_result want;
            n_checked++;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result word %0d: pc %0d in %0b out %0b/%02h halt %0b",
                             n_checked, got.next_pc, got.in_taken, got.out_valid,
                             got.out_byte, got.halted);
                return;
            end
            want = pending_results.pop_front();
            if (got.next_pc !== want.next_pc || got.in_taken !== want.in_taken ||
                got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
                got.halted !== want.halted) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("result %0d differs: expected pc %0d in %0b out %0b/%02h halt %0b",
                             n_checked, want.next_pc, want.in_taken, want.out_valid,
                             want.out_byte, want.halted);
                    $display("    got pc %0d in %0b out %0b/%02h halt %0b",
                             got.next_pc, got.in_taken, got.out_valid, got.out_byte,
                             got.halted);
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_instr_byte;
    logic [7:0] i_in_byte;
    logic       o_valid;
    logic       i_stall;
    logic [6:0] o_next_pc;
    logic       o_in_taken;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_halted;

    tape_scoreboard sb;
    logic [7:0]     code_rom [CODE_LEN];
    int             send_idle_pct = 0;
    int             stall_pct     = 0;
    int             hold_cycles   = 0;
    int             quiet         = 0;

    bracket_scan_tape_machine u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_instr_byte (i_instr_byte),
        .i_in_byte    (i_in_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_next_pc    (o_next_pc),
        .o_in_taken   (o_in_taken),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_halted     (o_halted)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Random payload byte
    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Any random byte except halt
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do b = rnd_byte(); while (b == CH_HALT);
        return b;
    endfunction

    // Random program with balanced brackets, no halt
    function automatic void build_code();
        int open_cnt;
        int left;
        int r;
        open_cnt = 0;
        for (int i = 0; i < CODE_LEN; i++) begin
            left = CODE_LEN - i;
            r    = $urandom_range(0, 99);
            if (open_cnt >= left) begin
                code_rom[i] = CH_CLOSE;
                open_cnt--;
            end else if (r < 12 && open_cnt + 1 <= left - 1) begin
                code_rom[i] = CH_OPEN;
                open_cnt++;
            end else if (r < 24 && open_cnt > 0) begin
                code_rom[i] = CH_CLOSE;
                open_cnt--;
            end else begin
                case ($urandom_range(0, 7))
                    0: code_rom[i] = CH_LEFT;
                    1: code_rom[i] = CH_RIGHT;
                    2, 3: code_rom[i] = CH_INC;
                    4: code_rom[i] = CH_DEC;
                    5: code_rom[i] = CH_IN;
                    6: code_rom[i] = CH_OUT;
                    default: code_rom[i] = 8'h20;
                endcase
            end
        end
    endfunction

    // Offer one word, hold it until taken, then record it
    task automatic send_word(input logic [7:0] instr, input logic [7:0] in_b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_instr_byte <= instr;
        i_in_byte    <= in_b;
        do @(posedge i_clk); while (o_stall);
        sb.note_word(instr, in_b);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Close any open scan by feeding the bracket that moves depth toward zero
    task automatic leave_scan();
        while (sb.m_seeking)
            send_word(sb.m_seek_back ? CH_OPEN : CH_CLOSE, rnd_byte());
    endtask

    // Enter a scan and push depth to +/-256 so it wraps to zero
    task automatic bracket_flood(input bit backward);
        leave_scan();
        send_word(CH_IN, backward ? 8'($urandom_range(1, 255)) : 8'h00);
        repeat (256) send_word(backward ? CH_CLOSE : CH_OPEN, rnd_byte());
        send_word(CH_OUT, rnd_byte());
    endtask

    // Receiver: random stall, or a counted hold when requested
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Result check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_word({o_next_pc, o_in_taken, o_out_valid, o_out_byte, o_halted});
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [7:0] b;
        sb           = new();
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_instr_byte = 8'h00;
        i_in_byte    = 8'h00;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: backward jump wrapping pc below zero, nested backward scan
        send_word(CH_IN, 8'hFF);
        send_word(CH_CLOSE, rnd_byte());
        send_word(8'h00, rnd_byte());
        send_word(CH_CLOSE, rnd_byte());
        send_word(CH_OPEN, rnd_byte());
        send_word(CH_OPEN, rnd_byte());
        // cell arithmetic wrap and tape pointer wrap both ways
        send_word(CH_OUT, rnd_byte());
        send_word(CH_INC, rnd_byte());
        send_word(CH_OUT, rnd_byte());
        send_word(CH_DEC, rnd_byte());
        send_word(CH_LEFT, rnd_byte());
        send_word(CH_OUT, rnd_byte());
        send_word(CH_INC, rnd_byte());
        send_word(CH_RIGHT, rnd_byte());
        send_word(CH_IN, 8'h00);
        // forward jump with nesting and junk bytes inside the scan
        send_word(CH_OPEN, rnd_byte());
        send_word(8'h00, rnd_byte());
        send_word(CH_OPEN, rnd_byte());
        send_word(8'hFF, rnd_byte());
        send_word(CH_CLOSE, rnd_byte());
        send_word(CH_CLOSE, rnd_byte());
        send_word(CH_IN, 8'h5A);
        send_word(CH_OUT, rnd_byte());
        wait_drained();

        // Random: mostly fetches from a balanced program at the predicted pc
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = SEND_IDLE[ph];
            stall_pct     = RECV_STALL[ph];
            for (int n = 0; n < 200; n++) begin
                if (n % 100 == 0) build_code();
                if (ph == 0 && n == 120) hold_cycles = 200;
                if ($urandom_range(0, 99) < 15)
                    b = noise_byte();
                else
                    b = code_rom[sb.m_pc];
                send_word(b, rnd_byte());
            end
            wait_drained();
        end

        // Depth wrap in both scan directions
        bracket_flood(1'b0);
        bracket_flood(1'b1);
        wait_drained();

        // Halt while scanning, then words that must be ignored
        leave_scan();
        send_word(CH_IN, 8'h00);
        send_word(CH_OPEN, rnd_byte());
        send_word(CH_DEC, rnd_byte());
        send_word(CH_HALT, rnd_byte());
        repeat (4) send_word(noise_byte(), rnd_byte());
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("covered %0d words, %0d results checked: %0d outputs, %0d reads, %0d scans",
                 sb.n_words, sb.n_checked, sb.n_out, sb.n_reads, sb.n_scans);
        $display("%0d results differed, %0d still pending", sb.n_errors,
                 sb.pending_results.size());
        if (sb.n_errors == 0 && sb.pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+src
src/bstm_pkg.sv
src/bstm_tape.sv
src/bracket_scan_tape_machine.sv
sim/tb_top.sv
